/* hw/rtl/pce_pkg.sv */
package pce_pkg;

    localparam int FIELD_BITS = 32;
    localparam int COORD_BITS = 32;
    localparam int COUNT_BITS = 16;
    localparam int SEG_BITS   = 16;
    localparam int WORD_BITS  = 32;
    localparam int MAX_WORDS  = 12;

    // points carry the full input range; only split points saturate to COORD_BITS
    localparam int PT_BITS   = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;
    localparam int SUM_BITS  = PT_BITS + 7;
    localparam int DIFF_BITS = PT_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;
    localparam int NUM_BITS  = $clog2(MAX_WORDS + 1);
    localparam int IDX_BITS  = $clog2(MAX_WORDS);

    typedef enum logic [2:0] {
        REQ_MOVE  = 3'd0,
        REQ_LINE  = 3'd1,
        REQ_QUAD  = 3'd2,
        REQ_CUBIC = 3'd3,
        REQ_ARC   = 3'd4,
        REQ_RESET = 3'd5
    } req_t;

    localparam logic [WORD_BITS-1:0] CODE_MOVE = WORD_BITS'(0);
    localparam logic [WORD_BITS-1:0] CODE_LINE = WORD_BITS'(1);
    localparam logic [WORD_BITS-1:0] CODE_QUAD = WORD_BITS'(2);
    localparam logic [WORD_BITS-1:0] CODE_ARC  = WORD_BITS'(4);

    typedef struct packed {
        logic [2:0]                   req_type;
        logic signed [FIELD_BITS-1:0] p1_x;
        logic signed [FIELD_BITS-1:0] p1_y;
        logic signed [FIELD_BITS-1:0] p2_x;
        logic signed [FIELD_BITS-1:0] p2_y;
        logic signed [FIELD_BITS-1:0] p3_x;
        logic signed [FIELD_BITS-1:0] p3_y;
        logic signed [FIELD_BITS-1:0] radius_x;
        logic signed [FIELD_BITS-1:0] radius_y;
        logic signed [FIELD_BITS-1:0] rotation;
        logic                         large_arc;
        logic                         ccw_sweep;
    } cmd_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] path_word;
        logic                 last_word;
        logic [SEG_BITS-1:0]  segments_so_far;
    } word_t;

    typedef struct packed {
        logic signed [PT_BITS-1:0] x;
        logic signed [PT_BITS-1:0] y;
    } point_t;

    // geometry of up to two quadratics (start, control, end); qa_c is the
    // end point of move, line and arc
    typedef struct packed {
        logic [2:0]                   kind;
        logic                         drop;
        point_t                       qa_p0;
        point_t                       qa_c;
        point_t                       qa_e;
        point_t                       qb_p0;
        point_t                       qb_c;
        point_t                       qb_e;
        logic signed [FIELD_BITS-1:0] rx;
        logic signed [FIELD_BITS-1:0] ry;
        logic signed [FIELD_BITS-1:0] rot;
        logic                         large_arc;
        logic                         sweep;
    } geom_t;

    typedef struct packed {
        geom_t                       g;
        logic signed [PROD_BITS-1:0] pa1;
        logic signed [PROD_BITS-1:0] pa2;
        logic signed [PROD_BITS-1:0] pb1;
        logic signed [PROD_BITS-1:0] pb2;
    } cross_t;

    typedef struct packed {
        logic [MAX_WORDS-1:0][WORD_BITS-1:0] words;
        logic [MAX_WORDS-1:0][SEG_BITS-1:0]  segs;
        logic [NUM_BITS-1:0]                 n;
    } build_t;

endpackage

/* hw/rtl/pce_split.sv */
module pce_split (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  pce_pkg::cmd_t  in_cmd,
    output logic           in_ready,
    output logic           out_valid,
    output pce_pkg::geom_t out_geom,
    input  logic           out_ready
);

    localparam int PT  = pce_pkg::PT_BITS;
    localparam int SUM = pce_pkg::SUM_BITS;
    localparam logic signed [SUM-1:0] SAT_HI =
        {{(SUM - pce_pkg::COORD_BITS + 1){1'b0}}, {(pce_pkg::COORD_BITS - 1){1'b1}}};
    localparam logic signed [SUM-1:0] SAT_LO = ~SAT_HI;

    logic           a_valid_reg;
    logic           a_valid_next;
    pce_pkg::cmd_t  a_reg;
    logic           b_valid_reg;
    logic           b_valid_next;
    pce_pkg::geom_t b_reg;
    pce_pkg::geom_t b_next;
    pce_pkg::point_t last_reg;
    pce_pkg::point_t last_next;

    logic            a_go;
    logic            line_drop;
    logic            arc_drop;
    pce_pkg::point_t p1;
    pce_pkg::point_t p2;
    pce_pkg::point_t p3;
    pce_pkg::point_t q1;
    pce_pkg::point_t mid;
    pce_pkg::point_t q3;

    function automatic logic signed [SUM-1:0] ext(input logic signed [PT-1:0] v);
        return SUM'(v);
    endfunction

    function automatic logic signed [PT-1:0] sat(input logic signed [SUM-1:0] v);
        logic signed [SUM-1:0] r;
        r = v;
        if (v > SAT_HI)
            r = SAT_HI;
        else if (v < SAT_LO)
            r = SAT_LO;
        return PT'(r);
    endfunction

    // floor((9a + 21b + 3c - d) / 32)
    function automatic logic signed [PT-1:0] outer(input logic signed [PT-1:0] a,
                                                   input logic signed [PT-1:0] b,
                                                   input logic signed [PT-1:0] c,
                                                   input logic signed [PT-1:0] d);
        logic signed [SUM-1:0] s;
        s = ((ext(a) <<< 3) + ext(a))
          + ((ext(b) <<< 4) + (ext(b) <<< 2) + ext(b))
          + ((ext(c) <<< 1) + ext(c))
          - ext(d);
        return sat(s >>> 5);
    endfunction

    // floor((a + 3b + 3c + d) / 8)
    function automatic logic signed [PT-1:0] centre(input logic signed [PT-1:0] a,
                                                    input logic signed [PT-1:0] b,
                                                    input logic signed [PT-1:0] c,
                                                    input logic signed [PT-1:0] d);
        logic signed [SUM-1:0] s;
        logic signed [SUM-1:0] bc;
        bc = ext(b) + ext(c);
        s  = ext(a) + (bc <<< 1) + bc + ext(d);
        return sat(s >>> 3);
    endfunction

    assign a_go     = a_valid_reg && (!b_valid_reg || out_ready);
    assign in_ready = !a_valid_reg || a_go;
    assign out_valid = b_valid_reg;
    assign out_geom  = b_reg;

    always_comb
    begin
        p1.x = PT'(a_reg.p1_x);
        p1.y = PT'(a_reg.p1_y);
        p2.x = PT'(a_reg.p2_x);
        p2.y = PT'(a_reg.p2_y);
        p3.x = PT'(a_reg.p3_x);
        p3.y = PT'(a_reg.p3_y);

        q1.x  = outer(last_reg.x, p1.x, p2.x, p3.x);
        q1.y  = outer(last_reg.y, p1.y, p2.y, p3.y);
        mid.x = centre(last_reg.x, p1.x, p2.x, p3.x);
        mid.y = centre(last_reg.y, p1.y, p2.y, p3.y);
        q3.x  = outer(p3.x, p2.x, p1.x, last_reg.x);
        q3.y  = outer(p3.y, p2.y, p1.y, last_reg.y);

        line_drop = (p1 == last_reg);
        arc_drop  = line_drop || (a_reg.radius_x == '0) || (a_reg.radius_y == '0);
    end

    always_comb
    begin
        b_next.kind  = a_reg.req_type;
        b_next.drop  = (a_reg.req_type == pce_pkg::REQ_LINE) ? line_drop :
                       (a_reg.req_type == pce_pkg::REQ_ARC) ? arc_drop : 1'b0;
        b_next.qa_p0 = last_reg;
        b_next.qa_c  = (a_reg.req_type == pce_pkg::REQ_CUBIC) ? q1 : p1;
        b_next.qa_e  = (a_reg.req_type == pce_pkg::REQ_CUBIC) ? mid : p2;
        b_next.qb_p0 = mid;
        b_next.qb_c  = q3;
        b_next.qb_e  = p3;
        b_next.rx    = a_reg.radius_x;
        b_next.ry    = a_reg.radius_y;
        b_next.rot   = a_reg.rotation;
        b_next.large_arc = a_reg.large_arc;
        b_next.sweep = a_reg.ccw_sweep;
    end

    // current point follows each command leaving a_reg, except a dropped arc or an unknown code
    always_comb
    begin
        last_next = last_reg;
        if (a_go)
        begin
            case (a_reg.req_type) inside
                pce_pkg::REQ_MOVE, pce_pkg::REQ_LINE: last_next = p1;
                pce_pkg::REQ_QUAD:  last_next = p2;
                pce_pkg::REQ_CUBIC: last_next = p3;
                pce_pkg::REQ_ARC:
                begin
                    if (!arc_drop)
                        last_next = p1;
                end
                pce_pkg::REQ_RESET: last_next = '0;
                default: last_next = last_reg;
            endcase
        end
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_valid && in_ready)
            a_valid_next = 1'b1;
        else if (a_go)
            a_valid_next = 1'b0;

        b_valid_next = b_valid_reg;
        if (a_go)
            b_valid_next = 1'b1;
        else if (out_ready)
            b_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            last_reg    <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            a_reg <= in_cmd;
        if (a_go)
            b_reg <= b_next;
    end

endmodule

/* hw/rtl/pce_cross.sv */
module pce_cross (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  pce_pkg::geom_t  in_geom,
    output logic            in_ready,
    output logic            out_valid,
    output pce_pkg::cross_t out_cross,
    input  logic            out_ready
);

    localparam int DW = pce_pkg::DIFF_BITS;

    logic            c_valid_reg;
    logic            c_valid_next;
    pce_pkg::cross_t c_reg;
    pce_pkg::cross_t c_next;

    logic signed [DW-1:0] a_v1x;
    logic signed [DW-1:0] a_v1y;
    logic signed [DW-1:0] a_v2x;
    logic signed [DW-1:0] a_v2y;
    logic signed [DW-1:0] b_v1x;
    logic signed [DW-1:0] b_v1y;
    logic signed [DW-1:0] b_v2x;
    logic signed [DW-1:0] b_v2y;

    function automatic logic signed [DW-1:0] diff(input logic signed [pce_pkg::PT_BITS-1:0] a,
                                                  input logic signed [pce_pkg::PT_BITS-1:0] b);
        return DW'(a) - DW'(b);
    endfunction

    assign in_ready  = !c_valid_reg || out_ready;
    assign out_valid = c_valid_reg;
    assign out_cross = c_reg;

    // control vectors of each quadratic; cross products compared downstream
    always_comb
    begin
        a_v1x = diff(in_geom.qa_c.x, in_geom.qa_p0.x);
        a_v1y = diff(in_geom.qa_c.y, in_geom.qa_p0.y);
        a_v2x = diff(in_geom.qa_e.x, in_geom.qa_c.x);
        a_v2y = diff(in_geom.qa_e.y, in_geom.qa_c.y);
        b_v1x = diff(in_geom.qb_c.x, in_geom.qb_p0.x);
        b_v1y = diff(in_geom.qb_c.y, in_geom.qb_p0.y);
        b_v2x = diff(in_geom.qb_e.x, in_geom.qb_c.x);
        b_v2y = diff(in_geom.qb_e.y, in_geom.qb_c.y);

        c_next.g   = in_geom;
        c_next.pa1 = a_v1x * a_v2y;
        c_next.pa2 = a_v1y * a_v2x;
        c_next.pb1 = b_v1x * b_v2y;
        c_next.pb2 = b_v1y * b_v2x;
    end

    always_comb
    begin
        c_valid_next = c_valid_reg;
        if (in_valid && in_ready)
            c_valid_next = 1'b1;
        else if (out_ready)
            c_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else
            c_valid_reg <= c_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            c_reg <= c_next;
    end

endmodule

/* hw/rtl/pce_record.sv */
module pce_record (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  pce_pkg::cross_t in_cross,
    output logic            in_ready,
    output logic            out_valid,
    output pce_pkg::build_t out_build,
    input  logic            out_ready
);

    localparam int QUAD_SLOTS = 6;
    localparam int SLOT_BITS  = 3;
    localparam int REC_BITS   = 3;
    localparam int CB         = pce_pkg::COUNT_BITS;
    localparam int NB         = pce_pkg::NUM_BITS;

    typedef struct packed {
        logic [QUAD_SLOTS-1:0][pce_pkg::WORD_BITS-1:0] w;
        logic [QUAD_SLOTS-1:0][REC_BITS-1:0]           r;
        logic [SLOT_BITS-1:0]                          n;
        logic [REC_BITS-1:0]                           nrec;
    } qlist_t;

    logic [CB-1:0] count_reg;
    logic [CB-1:0] count_next;

    qlist_t qa;
    qlist_t qb;
    logic [pce_pkg::MAX_WORDS-1:0][pce_pkg::WORD_BITS-1:0] words;
    logic [pce_pkg::MAX_WORDS-1:0][REC_BITS-1:0]           recs;
    logic [NB-1:0]       n;
    logic [REC_BITS-1:0] nrec;
    logic [NB-1:0]       j;
    pce_pkg::geom_t      g;

    function automatic logic [pce_pkg::WORD_BITS-1:0] cw(
        input logic signed [pce_pkg::PT_BITS-1:0] v);
        return pce_pkg::WORD_BITS'(v);
    endfunction

    function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] c,
                                              input logic [REC_BITS-1:0] k);
        logic [CB:0] s;
        s = {1'b0, c} + (CB + 1)'(k);
        return s[CB] ? '1 : s[CB-1:0];
    endfunction

    // one quadratic as words; collinear controls fall back to up to two lines,
    // each dropped when it ends where the path already stands
    function automatic qlist_t quad_list(input pce_pkg::point_t p0,
                                         input pce_pkg::point_t c,
                                         input pce_pkg::point_t e,
                                         input logic degen);
        qlist_t q;
        logic   l1;
        logic   l2;
        q  = '0;
        l1 = (c != p0);
        l2 = (e != c);
        if (!degen)
        begin
            q.w[0] = pce_pkg::CODE_QUAD;
            q.w[1] = cw(c.x);
            q.w[2] = cw(c.y);
            q.w[3] = cw(e.x);
            q.w[4] = cw(e.y);
            for (int i = 0; i < 5; i++)
                q.r[i] = REC_BITS'(1);
            q.n    = SLOT_BITS'(5);
            q.nrec = REC_BITS'(1);
        end
        else if (l1 && l2)
        begin
            q.w[0] = pce_pkg::CODE_LINE;
            q.w[1] = cw(c.x);
            q.w[2] = cw(c.y);
            q.w[3] = pce_pkg::CODE_LINE;
            q.w[4] = cw(e.x);
            q.w[5] = cw(e.y);
            for (int i = 0; i < 3; i++)
                q.r[i] = REC_BITS'(1);
            for (int i = 3; i < 6; i++)
                q.r[i] = REC_BITS'(2);
            q.n    = SLOT_BITS'(6);
            q.nrec = REC_BITS'(2);
        end
        else if (l1 || l2)
        begin
            q.w[0] = pce_pkg::CODE_LINE;
            q.w[1] = l1 ? cw(c.x) : cw(e.x);
            q.w[2] = l1 ? cw(c.y) : cw(e.y);
            for (int i = 0; i < 3; i++)
                q.r[i] = REC_BITS'(1);
            q.n    = SLOT_BITS'(3);
            q.nrec = REC_BITS'(1);
        end
        return q;
    endfunction

    assign in_ready  = out_ready;
    assign out_valid = in_valid;

    always_comb
    begin
        g  = in_cross.g;
        qa = quad_list(g.qa_p0, g.qa_c, g.qa_e, in_cross.pa1 == in_cross.pa2);
        qb = quad_list(g.qb_p0, g.qb_c, g.qb_e, in_cross.pb1 == in_cross.pb2);
        words = '0;
        recs  = '0;
        n     = '0;
        nrec  = '0;
        j     = '0;

        case (g.kind) inside
            pce_pkg::REQ_MOVE:
            begin
                words[0] = pce_pkg::CODE_MOVE;
                words[1] = cw(g.qa_c.x);
                words[2] = cw(g.qa_c.y);
                for (int i = 0; i < 3; i++)
                    recs[i] = REC_BITS'(1);
                n    = NB'(3);
                nrec = REC_BITS'(1);
            end
            pce_pkg::REQ_LINE:
            begin
                if (!g.drop)
                begin
                    words[0] = pce_pkg::CODE_LINE;
                    words[1] = cw(g.qa_c.x);
                    words[2] = cw(g.qa_c.y);
                    for (int i = 0; i < 3; i++)
                        recs[i] = REC_BITS'(1);
                    n    = NB'(3);
                    nrec = REC_BITS'(1);
                end
            end
            pce_pkg::REQ_QUAD, pce_pkg::REQ_CUBIC:
            begin
                if (g.kind != pce_pkg::REQ_CUBIC)
                begin
                    qb.n    = '0;
                    qb.nrec = '0;
                end
                // second quadratic packs in right behind the first
                for (int i = 0; i < pce_pkg::MAX_WORDS; i++)
                begin
                    j = NB'(i) - NB'(qa.n);
                    if (NB'(i) < NB'(qa.n))
                    begin
                        words[i] = qa.w[SLOT_BITS'(i)];
                        recs[i]  = qa.r[SLOT_BITS'(i)];
                    end
                    else if (j < NB'(qb.n))
                    begin
                        words[i] = qb.w[SLOT_BITS'(j)];
                        recs[i]  = qb.r[SLOT_BITS'(j)] + qa.nrec;
                    end
                end
                n    = NB'(qa.n) + NB'(qb.n);
                nrec = qa.nrec + qb.nrec;
            end
            pce_pkg::REQ_ARC:
            begin
                if (!g.drop)
                begin
                    words[0]  = pce_pkg::CODE_ARC;
                    words[1]  = pce_pkg::WORD_BITS'(g.rx);
                    words[2]  = pce_pkg::WORD_BITS'(g.ry);
                    words[3]  = pce_pkg::WORD_BITS'(g.rot);
                    words[4]  = '0;
                    words[5]  = '0;
                    words[6]  = pce_pkg::WORD_BITS'(g.large_arc);
                    words[7]  = pce_pkg::WORD_BITS'(g.sweep);
                    words[8]  = pce_pkg::WORD_BITS'(g.sweep);
                    words[9]  = cw(g.qa_c.x);
                    words[10] = cw(g.qa_c.y);
                    for (int i = 0; i < 11; i++)
                        recs[i] = REC_BITS'(1);
                    n    = NB'(11);
                    nrec = REC_BITS'(1);
                end
            end
            default:
            begin
                n = '0;
            end
        endcase

        out_build.words = words;
        out_build.n     = n;
        for (int i = 0; i < pce_pkg::MAX_WORDS; i++)
            out_build.segs[i] = pce_pkg::SEG_BITS'(sat_add(count_reg, recs[i]));
    end

    always_comb
    begin
        count_next = count_reg;
        if (in_valid && out_ready)
        begin
            if (g.kind == pce_pkg::REQ_RESET)
                count_next = '0;
            else
                count_next = sat_add(count_reg, nrec);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

/* hw/rtl/pce_word_buf.sv */
module pce_word_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  pce_pkg::build_t in_build,
    output logic            in_ready,
    output logic            word_valid,
    output pce_pkg::word_t  word,
    input  logic            word_stall
);

    localparam int NB = pce_pkg::NUM_BITS;
    localparam int IB = pce_pkg::IDX_BITS;

    logic            d_valid_reg;
    logic            d_valid_next;
    pce_pkg::build_t d_reg;
    logic [IB-1:0]   d_idx_reg;
    logic [IB-1:0]   d_idx_next;
    logic            at_last;
    logic            load;

    assign at_last  = (d_idx_reg == IB'(d_reg.n - NB'(1)));
    assign in_ready = !d_valid_reg || (!word_stall && at_last);
    assign load     = in_valid && in_ready;

    assign word_valid           = d_valid_reg;
    assign word.path_word       = d_reg.words[d_idx_reg];
    assign word.segments_so_far = d_reg.segs[d_idx_reg];
    assign word.last_word       = at_last;

    always_comb
    begin
        d_valid_next = d_valid_reg;
        d_idx_next   = d_idx_reg;
        if (load)
        begin
            // commands that make no words pass through without occupying the buffer
            d_valid_next = (in_build.n != '0);
            d_idx_next   = '0;
        end
        else if (d_valid_reg && !word_stall)
        begin
            if (at_last)
                d_valid_next = 1'b0;
            else
                d_idx_next = d_idx_reg + IB'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            d_idx_reg   <= '0;
        end
        else
        begin
            d_valid_reg <= d_valid_next;
            d_idx_reg   <= d_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            d_reg <= in_build;
    end

endmodule

/* hw/rtl/path_command_encoder.sv */
// channel   signals                       payload          direction
// command   cmd_valid, cmd_stall, cmd     pce_pkg::cmd_t   into the block
// words     word_valid, word_stall, word  pce_pkg::word_t  out of the block
//
// A command makes 3 words for move or line, 5 for a quadratic (6 or 3 when it
// flattens to two lines or one), up to 12 for a cubic and 11 for an arc, one word
// per cycle while word_stall is low; commands making no words put nothing out.
// After the command transfer the words pass the input, split, cross-product and
// output buffer registers, and up to three commands queue behind the buffer.
// Reset clears all valid flags, the current point to (0,0) and the count to 0;
// cmd_stall rises only when the queued stages are full behind a busy output buffer.
module path_command_encoder (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  pce_pkg::cmd_t  cmd,
    output logic           word_valid,
    input  logic           word_stall,
    output pce_pkg::word_t word
);

    logic            cmd_ready;
    logic            geom_valid;
    logic            geom_ready;
    pce_pkg::geom_t  geom;
    logic            cross_valid;
    logic            cross_ready;
    pce_pkg::cross_t prod;
    logic            build_valid;
    logic            build_ready;
    pce_pkg::build_t build;

    assign cmd_stall = !cmd_ready;

    pce_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_valid),
        .in_cmd    (cmd),
        .in_ready  (cmd_ready),
        .out_valid (geom_valid),
        .out_geom  (geom),
        .out_ready (geom_ready)
    );

    pce_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_valid),
        .in_geom   (geom),
        .in_ready  (geom_ready),
        .out_valid (cross_valid),
        .out_cross (prod),
        .out_ready (cross_ready)
    );

    pce_record u_record (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cross_valid),
        .in_cross  (prod),
        .in_ready  (cross_ready),
        .out_valid (build_valid),
        .out_build (build),
        .out_ready (build_ready)
    );

    pce_word_buf u_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (build_valid),
        .in_build   (build),
        .in_ready   (build_ready),
        .word_valid (word_valid),
        .word       (word),
        .word_stall (word_stall)
    );

`ifndef SYNTHESIS
    // every command's stream opens with a type word
    a_first_is_code: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(word_valid) |->
            (word.path_word == pce_pkg::CODE_MOVE || word.path_word == pce_pkg::CODE_LINE ||
             word.path_word == pce_pkg::CODE_QUAD || word.path_word == pce_pkg::CODE_ARC))
        else $error("stream does not open with a type word");

    a_next_is_code: assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid && !word_stall && word.last_word) |=> (!word_valid ||
             word.path_word == pce_pkg::CODE_MOVE || word.path_word == pce_pkg::CODE_LINE ||
             word.path_word == pce_pkg::CODE_QUAD || word.path_word == pce_pkg::CODE_ARC))
        else $error("command after last word does not open with a type word");

    // within one command the record count never falls, and the stream carries on
    a_count_rises: assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid && !word_stall && !word.last_word) |=>
            (word_valid && word.segments_so_far >= $past(word.segments_so_far)))
        else $error("record count fell or stream broke inside a command");
`endif

endmodule

/* test/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT     = 38;
    localparam int RAND_ITEMS   = 135;
    localparam int HOLD_LEN     = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    localparam logic [31:0] MAX_C = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_C = 32'h8000_0000;
    localparam logic [31:0] ONE   = 32'h0001_0000;
    localparam logic [31:0] M_ONE = 32'hFFFF_0000;

    localparam longint COORD_MAX = (longint'(1) <<< (pce_pkg::COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    typedef logic signed [2*pce_pkg::DIFF_BITS+1:0] cross_prod_t;

    class path_scoreboard;
        longint                         pen_x;
        longint                         pen_y;
        logic [pce_pkg::COUNT_BITS-1:0] records;
        pce_pkg::word_t                 pending[$];
        pce_pkg::word_t                 cmd_words[$];
        int                             mismatches;
        int                             words_checked;
        int                             n_moves;
        int                             n_lines;
        int                             n_quads;
        int                             n_arcs;

        function new();
            restart();
            mismatches    = 0;
            words_checked = 0;
            n_moves       = 0;
            n_lines       = 0;
            n_quads       = 0;
            n_arcs        = 0;
        endfunction

        function void restart();
            pen_x   = 0;
            pen_y   = 0;
            records = '0;
        endfunction

        function void count_record();
            if (records != '1)
                records++;
        endfunction

        function void put(longint v);
            pce_pkg::word_t w;
            if (cmd_words.size() >= pce_pkg::MAX_WORDS)
                return;
            w.path_word       = pce_pkg::WORD_BITS'(v);
            w.last_word       = 1'b0;
            w.segments_so_far = pce_pkg::SEG_BITS'(records);
            cmd_words = {cmd_words, w};
        endfunction

        function void add_line(longint x, longint y);
            if (x == pen_x && y == pen_y)
                return;
            count_record();
            n_lines++;
            put(pce_pkg::CODE_LINE);
            put(x);
            put(y);
            pen_x = x;
            pen_y = y;
        endfunction

        function void add_quad(longint cx, longint cy, longint ex, longint ey);
            cross_prod_t lhs;
            cross_prod_t rhs;
            lhs = cross_prod_t'(cx - pen_x) * cross_prod_t'(ey - cy);
            rhs = cross_prod_t'(cy - pen_y) * cross_prod_t'(ex - cx);
            if (lhs == rhs)
            begin
                // control vectors parallel: flatten to lines
                add_line(cx, cy);
                add_line(ex, ey);
                return;
            end
            count_record();
            n_quads++;
            put(pce_pkg::CODE_QUAD);
            put(cx);
            put(cy);
            put(ex);
            put(ey);
            pen_x = ex;
            pen_y = ey;
        endfunction

        function longint split_coord(longint a, longint b, longint c, longint d,
                                     longint ka, longint kb, longint kc, longint kd,
                                     int sh);
            longint v;
            v = (ka * a + kb * b + kc * c + kd * d) >>> sh;
            if (v > COORD_MAX)
                v = COORD_MAX;
            if (v < COORD_MIN)
                v = COORD_MIN;
            return v;
        endfunction

        function void note_command(pce_pkg::cmd_t c);
            longint x1, y1, x2, y2, x3, y3;
            longint q1x, q1y, mx, my, q3x, q3y;
            x1 = $signed(c.p1_x);
            y1 = $signed(c.p1_y);
            x2 = $signed(c.p2_x);
            y2 = $signed(c.p2_y);
            x3 = $signed(c.p3_x);
            y3 = $signed(c.p3_y);
            cmd_words = {};
            case (c.req_type)
                pce_pkg::REQ_MOVE:
                begin
                    count_record();
                    n_moves++;
                    put(pce_pkg::CODE_MOVE);
                    put(x1);
                    put(y1);
                    pen_x = x1;
                    pen_y = y1;
                end
                pce_pkg::REQ_LINE:
                    add_line(x1, y1);
                pce_pkg::REQ_QUAD:
                    add_quad(x1, y1, x2, y2);
                pce_pkg::REQ_CUBIC:
                begin
                    // halve at t = 1/2, each half approximated by one quadratic
                    q1x = split_coord(pen_x, x1, x2, x3, 9, 21, 3, -1, 5);
                    q1y = split_coord(pen_y, y1, y2, y3, 9, 21, 3, -1, 5);
                    mx  = split_coord(pen_x, x1, x2, x3, 1, 3, 3, 1, 3);
                    my  = split_coord(pen_y, y1, y2, y3, 1, 3, 3, 1, 3);
                    q3x = split_coord(pen_x, x1, x2, x3, -1, 3, 21, 9, 5);
                    q3y = split_coord(pen_y, y1, y2, y3, -1, 3, 21, 9, 5);
                    add_quad(q1x, q1y, mx, my);
                    add_quad(q3x, q3y, x3, y3);
                end
                pce_pkg::REQ_ARC:
                begin
                    if (!((x1 == pen_x && y1 == pen_y) || c.radius_x == 0
                          || c.radius_y == 0))
                    begin
                        count_record();
                        n_arcs++;
                        put(pce_pkg::CODE_ARC);
                        put($signed(c.radius_x));
                        put($signed(c.radius_y));
                        put($signed(c.rotation));
                        put(0);
                        put(0);
                        put(c.large_arc);
                        put(c.ccw_sweep);
                        put(c.ccw_sweep);
                        put(x1);
                        put(y1);
                        pen_x = x1;
                        pen_y = y1;
                    end
                end
                pce_pkg::REQ_RESET:
                    restart();
                default:
                    ;
            endcase
            if (cmd_words.size() > 0)
                cmd_words[cmd_words.size() - 1].last_word = 1'b1;
            pending = {pending, cmd_words};
        endfunction

        function void check_word(pce_pkg::word_t got);
            pce_pkg::word_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%t: unexpected word %h last %b segs %0d", $time,
                             got.path_word, got.last_word, got.segments_so_far);
                return;
            end
            want = pending.pop_front();
            words_checked++;
            if (got.path_word !== want.path_word || got.last_word !== want.last_word
                || got.segments_so_far !== want.segments_so_far)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%t: word %0d expected %h last %b segs %0d, got %h last %b segs %0d",
                             $time, words_checked, want.path_word, want.last_word,
                             want.segments_so_far, got.path_word, got.last_word,
                             got.segments_so_far);
            end
        endfunction
    endclass

    logic           clk          = 1'b0;
    logic           rst_n        = 1'b0;
    logic           cmd_valid    = 1'b0;
    logic           cmd_stall;
    pce_pkg::cmd_t  cmd          = '0;
    logic           word_valid;
    logic           word_stall   = 1'b0;
    pce_pkg::word_t word;
    logic           sink_quiet   = 1'b0;
    logic           hold_request = 1'b0;
    bit             source_quiet = 1'b0;
    int             idle_cycles  = 0;
    int             commands_sent = 0;
    path_scoreboard board;

    path_command_encoder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .word       (word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // output side: random stalls, quiet stretches, and one long hold-off
    initial
    begin : word_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request && hold_left == 0)
            begin
                hold_left = HOLD_LEN;
                hold_request <= 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                word_stall <= 1'b1;
            end
            else
                word_stall <= !sink_quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // checks every output transfer; watchdog on cycles with no transfer at all
    always @(posedge clk)
    begin
        if (rst_n && word_valid && !word_stall)
            board.check_word(word);
        if (!rst_n || (cmd_valid && !cmd_stall) || (word_valid && !word_stall))
            idle_cycles <= 0;
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("%t: no transfer for %0d cycles, %0d words outstanding", $time,
                     STALL_LIMIT, board.pending.size());
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic pce_pkg::cmd_t make_cmd(logic [2:0] kind, logic [31:0] ax,
                                               logic [31:0] ay, logic [31:0] bx,
                                               logic [31:0] by, logic [31:0] cx,
                                               logic [31:0] cy);
        pce_pkg::cmd_t c;
        c.req_type  = kind;
        c.p1_x      = ax;
        c.p1_y      = ay;
        c.p2_x      = bx;
        c.p2_y      = by;
        c.p3_x      = cx;
        c.p3_y      = cy;
        c.radius_x  = $urandom();
        c.radius_y  = $urandom();
        c.rotation  = $urandom();
        c.large_arc = $urandom_range(1);
        c.ccw_sweep = $urandom_range(1);
        return c;
    endfunction

    function automatic pce_pkg::cmd_t make_arc(logic [31:0] ax, logic [31:0] ay,
                                               logic [31:0] rx, logic [31:0] ry,
                                               logic [31:0] rot, logic big,
                                               logic sweep);
        pce_pkg::cmd_t c;
        c = make_cmd(pce_pkg::REQ_ARC, ax, ay, $urandom(), $urandom(), $urandom(),
                     $urandom());
        c.radius_x  = rx;
        c.radius_y  = ry;
        c.rotation  = rot;
        c.large_arc = big;
        c.ccw_sweep = sweep;
        return c;
    endfunction

    // within +/-16.0
    function automatic logic [31:0] pick_small();
        return 32'(int'($urandom_range(32 * 65536)) - 16 * 65536);
    endfunction

    function automatic logic [31:0] pick_coord();
        int sel;
        sel = $urandom_range(19);
        if (sel == 0)
            return MAX_C;
        if (sel == 1)
            return MIN_C;
        if (sel < 8)
            return $urandom();
        return pick_small();
    endfunction

    // mostly well-formed geometry, with degenerate cases relative to the pen
    function automatic pce_pkg::cmd_t random_command();
        logic [31:0] px, py, dx, dy;
        int          sel;
        int          sub;
        px  = 32'(board.pen_x);
        py  = 32'(board.pen_y);
        dx  = pick_small();
        dy  = pick_small();
        sel = $urandom_range(99);
        sub = $urandom_range(9);
        if (sel < 12)
            return make_cmd(pce_pkg::REQ_MOVE, pick_coord(), pick_coord(),
                            $urandom(), $urandom(), $urandom(), $urandom());
        if (sel < 28)
        begin
            if (sub < 2)
                return make_cmd(pce_pkg::REQ_LINE, px, py, $urandom(), $urandom(),
                                $urandom(), $urandom());
            return make_cmd(pce_pkg::REQ_LINE, pick_coord(), pick_coord(),
                            $urandom(), $urandom(), $urandom(), $urandom());
        end
        if (sel < 50)
        begin
            if (sub < 3)
                return make_cmd(pce_pkg::REQ_QUAD, px + dx, py + dy, px + 2 * dx,
                                py + 2 * dy, $urandom(), $urandom());
            if (sub == 3)
                return make_cmd(pce_pkg::REQ_QUAD, px, py, pick_coord(), pick_coord(),
                                $urandom(), $urandom());
            return make_cmd(pce_pkg::REQ_QUAD, pick_coord(), pick_coord(), pick_coord(),
                            pick_coord(), $urandom(), $urandom());
        end
        if (sel < 75)
        begin
            if (sub < 2)
                return make_cmd(pce_pkg::REQ_CUBIC, px + dx, py + dy, px + 2 * dx,
                                py + 2 * dy, px + 3 * dx, py + 3 * dy);
            return make_cmd(pce_pkg::REQ_CUBIC, pick_coord(), pick_coord(), pick_coord(),
                            pick_coord(), pick_coord(), pick_coord());
        end
        if (sel < 93)
        begin
            if (sub == 0)
                return make_arc(pick_coord(), pick_coord(), 32'h0, pick_coord(),
                                $urandom(), $urandom_range(1), $urandom_range(1));
            if (sub == 1)
                return make_arc(pick_coord(), pick_coord(), pick_coord(), 32'h0,
                                $urandom(), $urandom_range(1), $urandom_range(1));
            if (sub == 2)
                return make_arc(px, py, pick_coord(), pick_coord(), $urandom(),
                                $urandom_range(1), $urandom_range(1));
            return make_arc(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                            $urandom(), $urandom_range(1), $urandom_range(1));
        end
        if (sel < 96)
            return make_cmd(pce_pkg::REQ_RESET, $urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom(), $urandom());
        return make_cmd(3'($urandom_range(7, 6)), $urandom(), $urandom(), $urandom(),
                        $urandom(), $urandom(), $urandom());
    endfunction

    // valid stays high across back-to-back transfers; lowered only for idle cycles
    task automatic send(pce_pkg::cmd_t c);
        if (!source_quiet)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                cmd_valid <= 1'b0;
                @(posedge clk);
            end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        board.note_command(c);
        commands_sent++;
    endtask

    initial
    begin : stimulus
        board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: dropped commands, flattening, splits, saturation, arcs, odd codes
        send(make_cmd(pce_pkg::REQ_LINE, 0, 0, 0, 0, 0, 0));
        send(make_arc(0, 0, ONE, ONE, 0, 1'b0, 1'b1));
        send(make_cmd(pce_pkg::REQ_QUAD, ONE, ONE, 2 * ONE, 0, 0, 0));
        send(make_cmd(pce_pkg::REQ_LINE, 3 * ONE, 0, 0, 0, 0, 0));
        send(make_cmd(pce_pkg::REQ_QUAD, 4 * ONE, 0, 5 * ONE, 0, 0, 0));
        send(make_cmd(pce_pkg::REQ_QUAD, 5 * ONE, 0, 6 * ONE, ONE, 0, 0));
        send(make_cmd(pce_pkg::REQ_QUAD, 7 * ONE, ONE, 7 * ONE, ONE, 0, 0));
        send(make_cmd(pce_pkg::REQ_CUBIC, 8 * ONE, 4 * ONE, 10 * ONE, -4 * ONE,
                      12 * ONE, 0));
        send(make_cmd(pce_pkg::REQ_CUBIC, 13 * ONE, 0, 14 * ONE, 0, 15 * ONE, 0));
        send(make_cmd(pce_pkg::REQ_MOVE, MAX_C, MAX_C, 0, 0, 0, 0));
        send(make_cmd(pce_pkg::REQ_CUBIC, MAX_C, MAX_C, MAX_C, MAX_C, MIN_C, MIN_C));
        send(make_cmd(pce_pkg::REQ_MOVE, MIN_C, MIN_C, 0, 0, 0, 0));
        send(make_cmd(pce_pkg::REQ_CUBIC, MIN_C, MIN_C, MIN_C, MIN_C, MAX_C, MAX_C));
        send(make_cmd(pce_pkg::REQ_MOVE, MIN_C, MAX_C, 0, 0, 0, 0));
        send(make_arc(MAX_C, MIN_C, MAX_C, MIN_C, MIN_C, 1'b1, 1'b1));
        send(make_arc(0, ONE, 0, ONE, ONE, 1'b1, 1'b1));
        send(make_arc(0, ONE, ONE, 0, ONE, 1'b1, 1'b1));
        send(make_arc(0, ONE, 32'hFFFF_FFFF, ONE, MAX_C, 1'b0, 1'b0));
        send(make_arc(ONE, M_ONE, ONE, ONE, 0, 1'b1, 1'b0));
        send(make_cmd(3'd6, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C));
        send(make_cmd(3'd7, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C));
        send(make_cmd(pce_pkg::REQ_RESET, ONE, ONE, 0, 0, 0, 0));
        send(make_cmd(pce_pkg::REQ_LINE, 0, 0, 0, 0, 0, 0));
        send(make_cmd(pce_pkg::REQ_LINE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0));
        send(make_cmd(pce_pkg::REQ_QUAD, MAX_C, MIN_C, MIN_C, MAX_C, 0, 0));
        send(make_cmd(pce_pkg::REQ_MOVE, MIN_C, MIN_C, 0, 0, 0, 0));
        send(make_cmd(pce_pkg::REQ_QUAD, 0, 0, MAX_C, MAX_C, 0, 0));

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            source_quiet = (i >= 80 && i < 115);
            sink_quiet  <= source_quiet;
            // output held off while commands keep coming, so the input stalls
            if (i == 30)
                hold_request <= 1'b1;
            send(random_command());
        end

        source_quiet = 1'b1;
        sink_quiet  <= 1'b1;
        send(make_cmd(pce_pkg::REQ_LINE, pick_coord(), pick_coord(), 0, 0, 0, 0));
        send(make_arc(pick_coord(), pick_coord(), ONE, ONE, 0, 1'b1, 1'b0));
        send(make_cmd(pce_pkg::REQ_RESET, 0, 0, 0, 0, 0, 0));
        send(make_cmd(pce_pkg::REQ_MOVE, ONE, M_ONE, 0, 0, 0, 0));
        cmd_valid <= 1'b0;

        while (board.pending.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d commands in, %0d path words checked, %0d mismatches", commands_sent,
                 board.words_checked, board.mismatches);
        $display("records: %0d move, %0d line, %0d quadratic, %0d arc; long output hold-off",
                 board.n_moves, board.n_lines, board.n_quads, board.n_arcs);
        if (board.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
